>>> design/anchor_box_generator_defines.svh
// ---------------------------------------------------------------------------
// anchor_box_generator_defines.svh
// Assertion macros used by the anchor box generator checker.
// ---------------------------------------------------------------------------
`ifndef ANCHOR_BOX_GENERATOR_DEFINES_SVH
`define ANCHOR_BOX_GENERATOR_DEFINES_SVH

// same-cycle implication, disabled during reset
`define ABG_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled during reset
`define ABG_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> design/abg_pkg.sv
// ---------------------------------------------------------------------------
// abg_pkg
// Types, codes and constants of the anchor box generator.
// ---------------------------------------------------------------------------
package abg_pkg;

    localparam int DEF_SIZE_SLOTS = 4;
    localparam int DEF_MAX_RATIOS = 8;

    // item function codes
    localparam logic [1:0] FUNC_LOAD_SIZE  = 2'd0;
    localparam logic [1:0] FUNC_LOAD_RATIO = 2'd1;
    localparam logic [1:0] FUNC_GENERATE   = 2'd2;
    localparam logic [1:0] FUNC_UNUSED     = 2'd3;

    // configuration register indexes
    localparam logic [2:0] CFG_IMAGE_WIDTH   = 3'd0;
    localparam logic [2:0] CFG_IMAGE_HEIGHT  = 3'd1;
    localparam logic [2:0] CFG_STEP_X        = 3'd2;
    localparam logic [2:0] CFG_STEP_Y        = 3'd3;
    localparam logic [2:0] CFG_CENTER_OFFSET = 3'd4;
    localparam logic [2:0] CFG_CLIP_ENABLE   = 3'd5;
    localparam logic [2:0] CFG_SIZE_COUNT    = 3'd6;
    localparam logic [2:0] CFG_RATIO_COUNT   = 3'd7;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    // configuration reset values
    localparam logic [12:0] RST_IMAGE_WIDTH   = 13'd300;
    localparam logic [12:0] RST_IMAGE_HEIGHT  = 13'd300;
    localparam logic [15:0] RST_STEP_X        = 16'd128;
    localparam logic [15:0] RST_STEP_Y        = 16'd128;
    localparam logic [7:0]  RST_CENTER_OFFSET = 8'd128;
    localparam logic        RST_CLIP_ENABLE   = 1'b0;
    localparam logic [2:0]  RST_SIZE_COUNT    = 3'd1;
    localparam logic [3:0]  RST_RATIO_COUNT   = 4'd1;

    localparam logic [15:0] RATIO_ONE = 16'd4096;
    localparam logic [15:0] Q_ONE     = 16'h4000;
    localparam logic [15:0] SAT_POS   = 16'h7FFF;
    localparam logic [15:0] SAT_NEG   = 16'h8000;

    // datapath widths
    localparam int PROD_W     = 48;
    localparam int C2_W       = 37;
    localparam int SIDE_W     = 32;
    localparam int MAG_W      = 38;
    localparam int DIV_NUM_W  = 60;
    localparam int DIV_DEN_W  = 16;
    localparam int SQRT_W     = 64;

    typedef struct packed {
        logic [1:0]  func;
        logic [2:0]  entry_index;
        logic [15:0] base_side;
        logic [15:0] outer_side;
        logic [15:0] ratio_q12;
        logic [11:0] cell_x;
        logic [11:0] cell_y;
    } t_in_item;

    typedef struct packed {
        logic signed [15:0] x_min;
        logic signed [15:0] y_min;
        logic signed [15:0] x_max;
        logic signed [15:0] y_max;
        logic               last_box;
    } t_out_item;

    typedef enum logic [4:0] {
        OP_NONE,
        OP_TAKE,
        OP_MUL_CX,
        OP_MUL_CY,
        OP_SET_CY,
        OP_BOX_MIN,
        OP_MUL_MX,
        OP_SQRT_MX,
        OP_SET_MX,
        OP_RATIO_FIRST,
        OP_RATIO_NEXT,
        OP_MUL_MM,
        OP_MUL_AR,
        OP_SQRT_W,
        OP_DIV_H,
        OP_SQRT_H,
        OP_SET_H,
        OP_NORM,
        OP_NORM_ST,
        OP_EMIT,
        OP_SIZE_NEXT
    } t_op;

    typedef struct packed {
        t_op op;
    } t_cmd;

    typedef struct packed {
        logic div_done;
        logic sqrt_done;
        logic mx_nz;
        logic size_end;
        logic ratio_end;
        logic ratio_ok;
        logic edge_last;
        logic box_last;
        logic out_free;
    } t_status;

endpackage

>>> design/abg_in_if.sv
// ---------------------------------------------------------------------------
// abg_in_if
// Input item channel: valid, ready and one input item.
// ---------------------------------------------------------------------------
interface abg_in_if;
    logic              valid;
    logic              ready;
    abg_pkg::t_in_item item;

    modport source (output valid, output item, input ready);
    modport sink (input valid, input item, output ready);
endinterface

>>> design/abg_out_if.sv
// ---------------------------------------------------------------------------
// abg_out_if
// Result channel: valid, ready and one box.
// ---------------------------------------------------------------------------
interface abg_out_if;
    logic               valid;
    logic               ready;
    abg_pkg::t_out_item item;

    modport source (output valid, output item, input ready);
    modport sink (input valid, input item, output ready);
endinterface

>>> design/anchor_box_generator.sv
// Sequence: a load item is taken in the idle state; a generate item first computes the centers,
// then each min-size box, max box and ratio box in turn.
// The divider sets the pace: it runs for each edge of every box, and for a ratio box
// it also runs for the height, with the square root run for the width and the height.
// Throughput: one item at a time; a finished box waits in the output register.
// Reset: synchronous, active low; configuration returns to defaults, tables stay unset.
// ---------------------------------------------------------------------------
// anchor_box_generator
// Prior box generation for one feature-map cell, with size and ratio tables.
// ---------------------------------------------------------------------------
module anchor_box_generator #(
    parameter int SIZE_SLOTS = abg_pkg::DEF_SIZE_SLOTS,
    parameter int MAX_RATIOS = abg_pkg::DEF_MAX_RATIOS
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    abg_in_if.sink                         i_box_req,
    abg_out_if.source                      o_box,
    input  logic                           i_cfg_wr_en,
    input  logic [abg_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [abg_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    abg_pkg::t_cmd    cmd;
    abg_pkg::t_status status;

    abg_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_in_valid(i_box_req.valid),
        .i_func    (i_box_req.item.func),
        .o_in_ready(i_box_req.ready),
        .i_status  (status),
        .o_cmd     (cmd)
    );

    abg_datapath #(
        .SIZE_SLOTS(SIZE_SLOTS),
        .MAX_RATIOS(MAX_RATIOS)
    ) u_datapath (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (cmd),
        .o_status   (status),
        .i_item     (i_box_req.item),
        .i_cfg_wr_en(i_cfg_wr_en),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_out_valid(o_box.valid),
        .i_out_ready(o_box.ready),
        .o_out_item (o_box.item)
    );
endmodule

>>> design/abg_div.sv
// ---------------------------------------------------------------------------
// abg_div
// Restoring divider, one quotient bit per cycle.
// ---------------------------------------------------------------------------
module abg_div #(
    parameter int NUM_W = abg_pkg::DIV_NUM_W,
    parameter int DEN_W = abg_pkg::DIV_DEN_W
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [NUM_W-1:0] i_num,
    input  logic [DEN_W-1:0] i_den,
    output logic             o_done,
    output logic [NUM_W-1:0] o_quo
);
    localparam int CNT_W = $clog2(NUM_W + 1);

    logic             r_busy;
    logic             r_done;
    logic [CNT_W-1:0] r_cnt;
    logic [NUM_W-1:0] r_q;
    logic [DEN_W-1:0] r_rem;
    logic [DEN_W-1:0] r_den;

    logic [DEN_W:0] trial;
    logic [DEN_W:0] diff;
    logic           fits;
    logic           last_step;

    assign trial     = {r_rem, r_q[NUM_W-1]};
    assign diff      = trial - {1'b0, r_den};
    assign fits      = trial >= {1'b0, r_den};
    assign last_step = r_busy && (r_cnt == CNT_W'(NUM_W - 1));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= last_step && !i_start;
            if (i_start) begin
                r_busy <= 1'b1;
            end else if (last_step) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_q   <= i_num;
            r_rem <= '0;
            r_den <= i_den;
            r_cnt <= '0;
        end else if (r_busy) begin
            r_q   <= {r_q[NUM_W-2:0], fits};
            r_rem <= fits ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
            r_cnt <= r_cnt + 1'b1;
        end
    end

    assign o_done = r_done;
    assign o_quo  = r_q;
endmodule

>>> design/abg_sqrt.sv
// ---------------------------------------------------------------------------
// abg_sqrt
// Integer square root, floor, one result bit per cycle.
// ---------------------------------------------------------------------------
module abg_sqrt #(
    parameter int W = abg_pkg::SQRT_W
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_start,
    input  logic [W-1:0]   i_val,
    output logic           o_done,
    output logic [W/2-1:0] o_root
);
    logic         r_busy;
    logic         r_done;
    logic [W-1:0] r_v;
    logic [W-1:0] r_r;
    logic [W-1:0] r_b;

    logic [W-1:0] trial;
    logic         fits;
    logic         last_step;

    assign trial     = r_r + r_b;
    assign fits      = r_v >= trial;
    assign last_step = r_busy && r_b[0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= last_step && !i_start;
            if (i_start) begin
                r_busy <= 1'b1;
            end else if (last_step) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_v <= i_val;
            r_r <= '0;
            r_b <= {2'b01, {(W-2){1'b0}}};
        end else if (r_busy) begin
            if (fits) begin
                r_v <= r_v - trial;
                r_r <= (r_r >> 1) + r_b;
            end else begin
                r_r <= r_r >> 1;
            end
            r_b <= r_b >> 2;
        end
    end

    assign o_done = r_done;
    assign o_root = r_r[W/2-1:0];
endmodule

>>> design/abg_datapath.sv
// ---------------------------------------------------------------------------
// abg_datapath
// Tables, configuration, centers, box sides, edge normalization and the
// result register of the anchor box generator.
// ---------------------------------------------------------------------------
module abg_datapath #(
    parameter int SIZE_SLOTS = abg_pkg::DEF_SIZE_SLOTS,
    parameter int MAX_RATIOS = abg_pkg::DEF_MAX_RATIOS
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  abg_pkg::t_cmd                  i_cmd,
    output abg_pkg::t_status               o_status,
    input  abg_pkg::t_in_item              i_item,
    input  logic                           i_cfg_wr_en,
    input  logic [abg_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [abg_pkg::CFG_DATA_W-1:0] i_cfg_data,
    output logic                           o_out_valid,
    input  logic                           i_out_ready,
    output abg_pkg::t_out_item             o_out_item
);
    localparam int SW  = (SIZE_SLOTS > 1) ? $clog2(SIZE_SLOTS) : 1;
    localparam int SCW = $clog2(SIZE_SLOTS + 1);
    localparam int RW  = (MAX_RATIOS > 1) ? $clog2(MAX_RATIOS) : 1;
    localparam int RCW = $clog2(MAX_RATIOS + 1);

    // configuration
    logic [12:0] r_image_width;
    logic [12:0] r_image_height;
    logic [15:0] r_step_x;
    logic [15:0] r_step_y;
    logic [7:0]  r_center_offset;
    logic        r_clip;
    logic [2:0]  r_size_count;
    logic [3:0]  r_ratio_count;

    // tables
    logic [15:0] r_min_tab   [SIZE_SLOTS];
    logic [15:0] r_max_tab   [SIZE_SLOTS];
    logic [15:0] r_ratio_tab [MAX_RATIOS];

    logic [11:0]                  r_cell_x;
    logic [11:0]                  r_cell_y;
    logic [SCW-1:0]               r_s;
    logic [RCW-1:0]               r_r;
    logic [1:0]                   r_e;
    logic [abg_pkg::PROD_W-1:0]   r_prod;
    logic [abg_pkg::C2_W-1:0]     r_c2x;
    logic [abg_pkg::C2_W-1:0]     r_c2y;
    logic [31:0]                  r_mm;
    logic [abg_pkg::SIDE_W-1:0]   r_w;
    logic [abg_pkg::SIDE_W-1:0]   r_h;
    logic                         r_neg;
    logic                         r_last;
    logic [15:0]                  r_f [4];
    logic                         r_out_valid;
    abg_pkg::t_out_item           r_out_item;

    logic [SW-1:0]  load_sidx;
    logic [RW-1:0]  load_ridx;
    logic [15:0]    mn;
    logic [15:0]    mx;
    logic [15:0]    ar;
    logic [SCW-1:0] ns;
    logic [RCW-1:0] nr;
    logic           size_last;
    logic           any_from0;
    logic           any_after;
    logic           ratio_ok;

    assign load_sidx = SW'(i_item.entry_index);
    assign load_ridx = RW'(i_item.entry_index);
    assign mn = r_min_tab[r_s[SW-1:0]];
    assign mx = r_max_tab[r_s[SW-1:0]];
    assign ar = r_ratio_tab[r_r[RW-1:0]];

    assign ns = (32'(r_size_count) > SIZE_SLOTS) ? SCW'(SIZE_SLOTS) : SCW'(r_size_count);
    assign nr = (32'(r_ratio_count) > MAX_RATIOS) ? RCW'(MAX_RATIOS) : RCW'(r_ratio_count);
    assign size_last = ({1'b0, r_s} + 1'b1) >= {1'b0, ns};
    assign ratio_ok  = (r_r < nr) && (ar != '0) && (ar != abg_pkg::RATIO_ONE);

    // look ahead for any usable ratio, to flag the last box of the cell
    always_comb begin
        any_from0 = 1'b0;
        any_after = 1'b0;
        for (int j = 0; j < MAX_RATIOS; j++) begin
            if ((RCW'(j) < nr) && (r_ratio_tab[j] != '0)
                    && (r_ratio_tab[j] != abg_pkg::RATIO_ONE)) begin
                any_from0 = 1'b1;
                if (RCW'(j) > r_r) begin
                    any_after = 1'b1;
                end
            end
        end
    end

    // shared multiplier
    logic [31:0]                mul_a;
    logic [15:0]                mul_b;
    logic [abg_pkg::PROD_W-1:0] mul_p;

    always_comb begin
        mul_a = r_prod[31:0];
        mul_b = ar;
        case (i_cmd.op)
            abg_pkg::OP_MUL_CX: begin
                mul_a = 32'({r_cell_x, 8'd0}) + 32'(r_center_offset);
                mul_b = r_step_x;
            end
            abg_pkg::OP_MUL_CY: begin
                mul_a = 32'({r_cell_y, 8'd0}) + 32'(r_center_offset);
                mul_b = r_step_y;
            end
            abg_pkg::OP_MUL_MX: begin
                mul_a = 32'(mn);
                mul_b = mx;
            end
            abg_pkg::OP_MUL_MM: begin
                mul_a = 32'(mn);
                mul_b = mn;
            end
            default: begin
                mul_a = r_prod[31:0];
                mul_b = ar;
            end
        endcase
    end

    assign mul_p = mul_a * mul_b;

    // edge in units of 2^-13 pixel
    logic                         axis_y;
    logic [abg_pkg::C2_W-1:0]     c2;
    logic [abg_pkg::SIDE_W-1:0]   side;
    logic [12:0]                  d;
    logic [abg_pkg::MAG_W-1:0]    mag;
    logic                         edge_neg;

    assign axis_y = r_e[0];
    assign c2     = axis_y ? r_c2y : r_c2x;
    assign side   = axis_y ? r_h : r_w;
    assign d      = axis_y ? ((r_image_height == '0) ? 13'd1 : r_image_height)
                           : ((r_image_width == '0) ? 13'd1 : r_image_width);

    always_comb begin
        if (r_e[1]) begin
            mag      = abg_pkg::MAG_W'(c2) + abg_pkg::MAG_W'(side);
            edge_neg = 1'b0;
        end else if (abg_pkg::MAG_W'(c2) >= abg_pkg::MAG_W'(side)) begin
            mag      = abg_pkg::MAG_W'(c2) - abg_pkg::MAG_W'(side);
            edge_neg = 1'b0;
        end else begin
            mag      = abg_pkg::MAG_W'(side) - abg_pkg::MAG_W'(c2);
            edge_neg = 1'b1;
        end
    end

    // shared divider and square root
    logic                            div_start;
    logic [abg_pkg::DIV_NUM_W-1:0]   div_num;
    logic [abg_pkg::DIV_DEN_W-1:0]   div_den;
    logic                            div_done;
    logic [abg_pkg::DIV_NUM_W-1:0]   div_quo;
    logic                            sq_start;
    logic [abg_pkg::SQRT_W-1:0]      sq_val;
    logic                            sq_done;
    logic [abg_pkg::SQRT_W/2-1:0]    sq_root;

    assign div_start = (i_cmd.op == abg_pkg::OP_NORM) || (i_cmd.op == abg_pkg::OP_DIV_H);
    assign div_num   = (i_cmd.op == abg_pkg::OP_DIV_H)
                     ? {r_mm, 28'd0}
                     : abg_pkg::DIV_NUM_W'({mag, 2'b00}) + abg_pkg::DIV_NUM_W'(d);
    assign div_den   = (i_cmd.op == abg_pkg::OP_DIV_H)
                     ? ar : abg_pkg::DIV_DEN_W'({d, 1'b0});

    assign sq_start = (i_cmd.op == abg_pkg::OP_SQRT_MX) || (i_cmd.op == abg_pkg::OP_SQRT_W)
                   || (i_cmd.op == abg_pkg::OP_SQRT_H);

    always_comb begin
        case (i_cmd.op)
            abg_pkg::OP_SQRT_MX: sq_val = abg_pkg::SQRT_W'({r_prod[31:0], 16'd0});
            abg_pkg::OP_SQRT_W:  sq_val = abg_pkg::SQRT_W'({r_prod, 4'd0});
            default:             sq_val = abg_pkg::SQRT_W'(div_quo);
        endcase
    end

    abg_div #(
        .NUM_W(abg_pkg::DIV_NUM_W),
        .DEN_W(abg_pkg::DIV_DEN_W)
    ) u_div (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_start(div_start),
        .i_num  (div_num),
        .i_den  (div_den),
        .o_done (div_done),
        .o_quo  (div_quo)
    );

    abg_sqrt #(
        .W(abg_pkg::SQRT_W)
    ) u_sqrt (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_start(sq_start),
        .i_val  (sq_val),
        .o_done (sq_done),
        .o_root (sq_root)
    );

    // rounded quotient -> saturated, optionally clipped Q2.14
    logic [15:0] fval;

    always_comb begin
        if (r_clip) begin
            if (r_neg) begin
                fval = '0;
            end else if (div_quo > abg_pkg::DIV_NUM_W'(abg_pkg::Q_ONE)) begin
                fval = abg_pkg::Q_ONE;
            end else begin
                fval = div_quo[15:0];
            end
        end else if (r_neg) begin
            if (div_quo >= abg_pkg::DIV_NUM_W'(abg_pkg::SAT_NEG)) begin
                fval = abg_pkg::SAT_NEG;
            end else begin
                fval = 16'd0 - div_quo[15:0];
            end
        end else if (div_quo >= abg_pkg::DIV_NUM_W'(abg_pkg::SAT_POS)) begin
            fval = abg_pkg::SAT_POS;
        end else begin
            fval = div_quo[15:0];
        end
    end

    // configuration and result valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_image_width   <= abg_pkg::RST_IMAGE_WIDTH;
            r_image_height  <= abg_pkg::RST_IMAGE_HEIGHT;
            r_step_x        <= abg_pkg::RST_STEP_X;
            r_step_y        <= abg_pkg::RST_STEP_Y;
            r_center_offset <= abg_pkg::RST_CENTER_OFFSET;
            r_clip          <= abg_pkg::RST_CLIP_ENABLE;
            r_size_count    <= abg_pkg::RST_SIZE_COUNT;
            r_ratio_count   <= abg_pkg::RST_RATIO_COUNT;
            r_out_valid     <= 1'b0;
        end else begin
            if (i_cfg_wr_en) begin
                case (i_cfg_idx)
                    abg_pkg::CFG_IMAGE_WIDTH:   r_image_width   <= i_cfg_data[12:0];
                    abg_pkg::CFG_IMAGE_HEIGHT:  r_image_height  <= i_cfg_data[12:0];
                    abg_pkg::CFG_STEP_X:        r_step_x        <= i_cfg_data;
                    abg_pkg::CFG_STEP_Y:        r_step_y        <= i_cfg_data;
                    abg_pkg::CFG_CENTER_OFFSET: r_center_offset <= i_cfg_data[7:0];
                    abg_pkg::CFG_CLIP_ENABLE:   r_clip          <= i_cfg_data[0];
                    abg_pkg::CFG_SIZE_COUNT:    r_size_count    <= i_cfg_data[2:0];
                    abg_pkg::CFG_RATIO_COUNT:   r_ratio_count   <= i_cfg_data[3:0];
                    default: ;
                endcase
            end
            if (i_cmd.op == abg_pkg::OP_EMIT) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        case (i_cmd.op)
            abg_pkg::OP_TAKE: begin
                case (i_item.func)
                    abg_pkg::FUNC_LOAD_SIZE: begin
                        if (32'(i_item.entry_index) < SIZE_SLOTS) begin
                            r_min_tab[load_sidx] <= i_item.base_side;
                            r_max_tab[load_sidx] <= i_item.outer_side;
                        end
                    end
                    abg_pkg::FUNC_LOAD_RATIO: begin
                        if (32'(i_item.entry_index) < MAX_RATIOS) begin
                            r_ratio_tab[load_ridx] <= i_item.ratio_q12;
                        end
                    end
                    default: begin
                        r_cell_x <= i_item.cell_x;
                        r_cell_y <= i_item.cell_y;
                    end
                endcase
            end
            abg_pkg::OP_MUL_CX: r_prod <= mul_p;
            abg_pkg::OP_MUL_CY: begin
                r_c2x  <= {r_prod[abg_pkg::C2_W-2:0], 1'b0};
                r_prod <= mul_p;
            end
            abg_pkg::OP_SET_CY: begin
                r_c2y <= {r_prod[abg_pkg::C2_W-2:0], 1'b0};
                r_s   <= '0;
            end
            abg_pkg::OP_BOX_MIN: begin
                r_w    <= abg_pkg::SIDE_W'({mn, 8'd0});
                r_h    <= abg_pkg::SIDE_W'({mn, 8'd0});
                r_e    <= '0;
                r_last <= size_last && (mx == '0) && !any_from0;
            end
            abg_pkg::OP_MUL_MX, abg_pkg::OP_MUL_MM: r_prod <= mul_p;
            abg_pkg::OP_SET_MX: begin
                r_w    <= sq_root;
                r_h    <= sq_root;
                r_e    <= '0;
                r_last <= size_last && !any_from0;
            end
            abg_pkg::OP_RATIO_FIRST: r_r <= '0;
            abg_pkg::OP_RATIO_NEXT:  r_r <= r_r + 1'b1;
            abg_pkg::OP_MUL_AR: begin
                r_mm   <= r_prod[31:0];
                r_prod <= mul_p;
            end
            abg_pkg::OP_DIV_H: r_w <= sq_root;
            abg_pkg::OP_SET_H: begin
                r_h    <= sq_root;
                r_e    <= '0;
                r_last <= size_last && !any_after;
            end
            abg_pkg::OP_NORM: r_neg <= edge_neg;
            abg_pkg::OP_NORM_ST: begin
                r_f[r_e] <= fval;
                r_e      <= r_e + 1'b1;
            end
            abg_pkg::OP_EMIT: begin
                r_out_item.x_min    <= r_f[0];
                r_out_item.y_min    <= r_f[1];
                r_out_item.x_max    <= r_f[2];
                r_out_item.y_max    <= r_f[3];
                r_out_item.last_box <= r_last;
            end
            abg_pkg::OP_SIZE_NEXT: r_s <= r_s + 1'b1;
            default: ;
        endcase
    end

    assign o_status.div_done  = div_done;
    assign o_status.sqrt_done = sq_done;
    assign o_status.mx_nz     = (mx != '0);
    assign o_status.size_end  = (r_s >= ns);
    assign o_status.ratio_end = (r_r >= nr);
    assign o_status.ratio_ok  = ratio_ok;
    assign o_status.edge_last = (r_e == 2'd3);
    assign o_status.box_last  = r_last;
    assign o_status.out_free  = !r_out_valid || i_out_ready;

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;
endmodule

>>> design/abg_ctrl.sv
// ---------------------------------------------------------------------------
// abg_ctrl
// Sequencer of the anchor box generator: walks sizes, the optional max box
// and the ratios, and runs each box through sides, edges and the result.
// ---------------------------------------------------------------------------
module abg_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    input  logic [1:0]       i_func,
    output logic             o_in_ready,
    input  abg_pkg::t_status i_status,
    output abg_pkg::t_cmd    o_cmd
);
    typedef enum logic [4:0] {
        S_IDLE, S_CX, S_CY, S_CY2, S_SIZE, S_NORM, S_NWAIT, S_EMIT,
        S_MX, S_MXSQ, S_MXW, S_RSTART, S_RCHK, S_MULAR, S_SQW, S_SQWW,
        S_DIVW, S_SQHW, S_RNEXT
    } t_state;

    typedef enum logic [1:0] {
        RET_MIN, RET_MX, RET_RATIO
    } t_ret;

    t_state r_state, n_state;
    t_ret   r_ret, n_ret;

    always_comb begin
        n_state    = r_state;
        n_ret      = r_ret;
        o_cmd.op   = abg_pkg::OP_NONE;
        o_in_ready = (r_state == S_IDLE);
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.op = abg_pkg::OP_TAKE;
                    if (i_func == abg_pkg::FUNC_GENERATE) begin
                        n_state = S_CX;
                    end
                end
            end
            S_CX: begin
                o_cmd.op = abg_pkg::OP_MUL_CX;
                n_state  = S_CY;
            end
            S_CY: begin
                o_cmd.op = abg_pkg::OP_MUL_CY;
                n_state  = S_CY2;
            end
            S_CY2: begin
                o_cmd.op = abg_pkg::OP_SET_CY;
                n_state  = S_SIZE;
            end
            S_SIZE: begin
                if (i_status.size_end) begin
                    n_state = S_IDLE;
                end else begin
                    o_cmd.op = abg_pkg::OP_BOX_MIN;
                    n_ret    = RET_MIN;
                    n_state  = S_NORM;
                end
            end
            S_NORM: begin
                o_cmd.op = abg_pkg::OP_NORM;
                n_state  = S_NWAIT;
            end
            S_NWAIT: begin
                if (i_status.div_done) begin
                    o_cmd.op = abg_pkg::OP_NORM_ST;
                    n_state  = i_status.edge_last ? S_EMIT : S_NORM;
                end
            end
            S_EMIT: begin
                if (i_status.out_free) begin
                    o_cmd.op = abg_pkg::OP_EMIT;
                    if (i_status.box_last) begin
                        n_state = S_IDLE;
                    end else begin
                        case (r_ret)
                            RET_MIN: n_state = S_MX;
                            RET_MX:  n_state = S_RSTART;
                            default: n_state = S_RNEXT;
                        endcase
                    end
                end
            end
            S_MX: begin
                if (i_status.mx_nz) begin
                    o_cmd.op = abg_pkg::OP_MUL_MX;
                    n_state  = S_MXSQ;
                end else begin
                    n_state = S_RSTART;
                end
            end
            S_MXSQ: begin
                o_cmd.op = abg_pkg::OP_SQRT_MX;
                n_state  = S_MXW;
            end
            S_MXW: begin
                if (i_status.sqrt_done) begin
                    o_cmd.op = abg_pkg::OP_SET_MX;
                    n_ret    = RET_MX;
                    n_state  = S_NORM;
                end
            end
            S_RSTART: begin
                o_cmd.op = abg_pkg::OP_RATIO_FIRST;
                n_state  = S_RCHK;
            end
            S_RCHK: begin
                if (i_status.ratio_end) begin
                    o_cmd.op = abg_pkg::OP_SIZE_NEXT;
                    n_state  = S_SIZE;
                end else if (i_status.ratio_ok) begin
                    o_cmd.op = abg_pkg::OP_MUL_MM;
                    n_state  = S_MULAR;
                end else begin
                    // skip ratio one and zero
                    o_cmd.op = abg_pkg::OP_RATIO_NEXT;
                end
            end
            S_MULAR: begin
                o_cmd.op = abg_pkg::OP_MUL_AR;
                n_state  = S_SQW;
            end
            S_SQW: begin
                o_cmd.op = abg_pkg::OP_SQRT_W;
                n_state  = S_SQWW;
            end
            S_SQWW: begin
                if (i_status.sqrt_done) begin
                    o_cmd.op = abg_pkg::OP_DIV_H;
                    n_state  = S_DIVW;
                end
            end
            S_DIVW: begin
                if (i_status.div_done) begin
                    o_cmd.op = abg_pkg::OP_SQRT_H;
                    n_state  = S_SQHW;
                end
            end
            S_SQHW: begin
                if (i_status.sqrt_done) begin
                    o_cmd.op = abg_pkg::OP_SET_H;
                    n_ret    = RET_RATIO;
                    n_state  = S_NORM;
                end
            end
            S_RNEXT: begin
                o_cmd.op = abg_pkg::OP_RATIO_NEXT;
                n_state  = S_RCHK;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_ret   <= RET_MIN;
        end else begin
            r_state <= n_state;
            r_ret   <= n_ret;
        end
    end
endmodule

>>> design/abg_checker.sv
// ---------------------------------------------------------------------------
// abg_checker
// Port-level checks of the anchor box generator, bound to the top level.
// ---------------------------------------------------------------------------
`include "anchor_box_generator_defines.svh"

module abg_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_in_valid,
    input logic       i_in_ready,
    input logic [1:0] i_in_func,
    input logic       i_out_valid,
    input logic       i_out_ready,
    input logic       i_out_last
);
    logic in_xfer;
    logic gen_xfer;

    assign in_xfer  = i_in_valid && i_in_ready;
    assign gen_xfer = in_xfer && (i_in_func == abg_pkg::FUNC_GENERATE);

    `ABG_ASSERT_NXT(a_out_hold, i_clk, i_rst_n, i_out_valid && !i_out_ready, i_out_valid, "box dropped while stalled")
    `ABG_ASSERT_NXT(a_busy_after_gen, i_clk, i_rst_n, gen_xfer, !i_in_ready, "input taken during cell generation")
    `ABG_ASSERT_NXT(a_load_no_box, i_clk, i_rst_n, in_xfer && !gen_xfer && !i_out_valid, !i_out_valid, "box from a load item")
    `ABG_ASSERT_IMP(a_idle_last, i_clk, i_rst_n, i_in_ready && i_out_valid, i_out_last, "idle with a box that is not the last of its cell")
endmodule

bind anchor_box_generator abg_checker u_abg_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_in_valid (i_box_req.valid),
    .i_in_ready (i_box_req.ready),
    .i_in_func  (i_box_req.item.func),
    .i_out_valid(o_box.valid),
    .i_out_ready(o_box.ready),
    .i_out_last (o_box.item.last_box)
);
